@@ rtl/core/odgp_pkg.sv @@
// ----------------------------------------------------------------------------
// odgp_pkg
// Shared types and constants for the ordered-dither gray packer.
// ----------------------------------------------------------------------------
package odgp_pkg;

    localparam int COORD_BITS  = 12;
    localparam int APB_DW      = 64;
    localparam int APB_AW      = 5;

    // register indexes (address bits [4:3])
    localparam logic [1:0] REG_DITHER_LOW  = 2'd0;
    localparam logic [1:0] REG_DITHER_HIGH = 2'd1;
    localparam logic [1:0] REG_FAST_MODE   = 2'd2;

    localparam logic signed [12:0] FAST_THRESHOLD = 13'sd512;
    localparam logic [3:0]         GRAY_MAX       = 4'd15;
    localparam int                 GRAY_SHIFT     = 6;

    typedef struct packed {
        logic [7:0]            red;
        logic [7:0]            green;
        logic [7:0]            blue;
        logic [COORD_BITS-1:0] column;
        logic [COORD_BITS-1:0] row;
        logic                  segment_end;
    } pixel_t;

    typedef struct packed {
        logic [15:0] packed_word;
        logic        last_word;
    } word_t;

endpackage

@@ rtl/core/ordered_dither_gray4_packer.sv @@
// ----------------------------------------------------------------------------
// ordered_dither_gray4_packer
// 4x4 ordered dither of RGB888 pixels to 4-bit gray, packed four per word.
// ----------------------------------------------------------------------------
// One pixel is accepted per clock and a packed 16-bit word comes out whenever
// slot 3 is filled or at segment end. From the input register, luminance,
// dither and packing logic feed the output register. Throughput is one pixel per
// clock as long as the word consumer keeps m_ready high; a stalled output word
// holds the pipeline. The dither table (sixteen signed bytes) and the mode bit
// are set through the APB port at byte addresses 0x00, 0x08 and 0x10; they must
// be written while idle, which the block itself does not enforce.
module ordered_dither_gray4_packer (
    input  logic                          aclk,
    input  logic                          aresetn,
    // pixel input
    input  logic                          s_valid,
    output logic                          s_ready,
    input  odgp_pkg::pixel_t              s_data,
    // packed word output
    output logic                          m_valid,
    input  logic                          m_ready,
    output odgp_pkg::word_t               m_data,
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [odgp_pkg::APB_AW-1:0]   paddr,
    input  logic [odgp_pkg::APB_DW-1:0]   pwdata,
    output logic [odgp_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [63:0] dither_low_reg;
    logic [63:0] dither_high_reg;
    logic        fast_mode_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dither_low_reg  <= '0;
            dither_high_reg <= '0;
            fast_mode_reg   <= 1'b0;
        end else if (cfg_wr) begin
            case (paddr[4:3])
                odgp_pkg::REG_DITHER_LOW:  dither_low_reg  <= pwdata;
                odgp_pkg::REG_DITHER_HIGH: dither_high_reg <= pwdata;
                odgp_pkg::REG_FAST_MODE:   fast_mode_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            odgp_pkg::REG_DITHER_LOW:  prdata = dither_low_reg;
            odgp_pkg::REG_DITHER_HIGH: prdata = dither_high_reg;
            odgp_pkg::REG_FAST_MODE:   prdata = {63'd0, fast_mode_reg};
            default:                   prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline control
    // ------------------------------------------------------------------
    logic             in_valid_reg;
    odgp_pkg::pixel_t in_reg;
    logic             out_valid_reg;
    odgp_pkg::word_t  out_reg;
    logic             advance;

    assign advance = !out_valid_reg || m_ready;
    assign s_ready = advance || !in_valid_reg;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    // ------------------------------------------------------------------
    // luminance and dither
    // ------------------------------------------------------------------
    logic [9:0]         luma;
    logic [3:0]         tbl_idx;
    logic [63:0]        bank;
    logic signed [7:0]  offset;
    logic signed [11:0] q_sum;
    logic [3:0]         q_level;
    logic signed [12:0] f_sum;
    logic [3:0]         pix;

    always_comb begin
        luma    = 10'(in_reg.red) + {1'b0, in_reg.green, 1'b0} + 10'(in_reg.blue);
        tbl_idx = {in_reg.row[1:0], in_reg.column[1:0]};
        bank    = tbl_idx[3] ? dither_high_reg : dither_low_reg;
        offset  = signed'(bank[tbl_idx[2:0]*8 +: 8]);

        q_sum = signed'({2'b00, luma}) + 12'(offset);
        if (q_sum < 0) begin
            q_level = 4'd0;
        end else if (q_sum[11:odgp_pkg::GRAY_SHIFT] > 6'(odgp_pkg::GRAY_MAX)) begin
            q_level = odgp_pkg::GRAY_MAX;
        end else begin
            q_level = q_sum[odgp_pkg::GRAY_SHIFT +: 4];
        end

        // offset * 16 as a shift
        f_sum = signed'({3'b000, luma}) + signed'({offset[7], offset, 4'b0000});

        if (fast_mode_reg) begin
            pix = (f_sum < odgp_pkg::FAST_THRESHOLD) ? 4'd0 : odgp_pkg::GRAY_MAX;
        end else begin
            pix = q_level;
        end
    end

    // ------------------------------------------------------------------
    // nibble packing
    // ------------------------------------------------------------------
    logic [15:0] buf_reg,  buf_next;
    logic [1:0]  slot_reg, slot_next;
    logic        pend_reg, pend_next;
    logic [1:0]  slot_cur;
    logic [15:0] word_cur;
    logic        emit;
    logic        step;

    assign step = in_valid_reg && advance;

    always_comb begin
        slot_cur = pend_reg ? slot_reg : in_reg.column[1:0];
        word_cur = pend_reg ? buf_reg : 16'd0;
        word_cur[(2'd3 - slot_cur)*4 +: 4] = word_cur[(2'd3 - slot_cur)*4 +: 4] | pix;
        emit     = (slot_cur == 2'd3) || in_reg.segment_end;

        if (emit) begin
            buf_next  = 16'd0;
            slot_next = 2'd0;
            pend_next = 1'b0;
        end else begin
            buf_next  = word_cur;
            slot_next = slot_cur + 2'd1;
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg  <= '0;
            slot_reg <= '0;
            pend_reg <= 1'b0;
        end else if (step) begin
            buf_reg  <= buf_next;
            slot_reg <= slot_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= step && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && emit) begin
            out_reg.packed_word <= word_cur;
            out_reg.last_word   <= in_reg.segment_end;
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_idle_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        !pend_reg |-> slot_reg == 2'd0)
        else $error("slot not cleared while no word pending");

    a_pending_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> slot_reg != 2'd0)
        else $error("pending word points at first slot");

    a_segment_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && in_reg.segment_end) |=> (!pend_reg && m_valid && m_data.last_word))
        else $error("segment end did not flush the word");

    a_stall_holds_state: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> ($stable(buf_reg) && $stable(pend_reg)))
        else $error("packing state moved during output stall");

endmodule

@@ tb/odgp_word_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// odgp_word_checker
// Snoops pixel, word and APB traffic of the packer, predicts every packed
// word from the accepted pixels and compares it field by field.
// ----------------------------------------------------------------------------
module odgp_word_checker (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    input  logic                        s_ready,
    input  odgp_pkg::pixel_t            s_data,
    input  logic                        m_valid,
    input  logic                        m_ready,
    input  odgp_pkg::word_t             m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [odgp_pkg::APB_AW-1:0] paddr,
    input  logic [odgp_pkg::APB_DW-1:0] pwdata,
    input  logic                        pready,
    output int                          mismatches,
    output int                          words_due
);

    localparam int REPORT_LIMIT = 10;

    logic [63:0] dither_low;
    logic [63:0] dither_high;
    logic        fast_mode;

    logic [15:0] word_buf;
    logic [1:0]  slot;
    logic        pending;

    odgp_pkg::word_t expected_words[$];
    int              errors;

    function automatic logic [3:0] dither_gray(input odgp_pkg::pixel_t px);
        logic [63:0] bank;
        logic [7:0]  raw;
        int          luma;
        int          offset;
        int          level;
        // row bit 1 picks the bank, {row[0], column[1:0]} the byte
        bank   = px.row[1] ? dither_high : dither_low;
        raw    = bank[{px.row[0], px.column[1:0]} * 8 +: 8];
        offset = int'($signed(raw));
        luma   = int'(px.red) + 2 * int'(px.green) + int'(px.blue);
        if (fast_mode) begin
            return (luma + offset * 16 < odgp_pkg::FAST_THRESHOLD) ?
                   4'd0 : odgp_pkg::GRAY_MAX;
        end
        level = luma + offset;
        if (level < 0) begin
            level = 0;
        end
        level = level >> odgp_pkg::GRAY_SHIFT;
        return (level > int'(odgp_pkg::GRAY_MAX)) ? odgp_pkg::GRAY_MAX : level[3:0];
    endfunction

    // Returns 1 when this pixel closes a word.
    function automatic bit pack_pixel(input odgp_pkg::pixel_t px,
                                      output odgp_pkg::word_t word);
        logic [3:0] gray;
        word = '0;
        gray = dither_gray(px);
        if (!pending) begin
            word_buf = '0;
            slot     = px.column[1:0];
        end
        word_buf[15 - 4 * slot -: 4] = gray;
        if (slot == 2'd3 || px.segment_end) begin
            word.packed_word = word_buf;
            word.last_word   = px.segment_end;
            word_buf = '0;
            slot     = '0;
            pending  = 1'b0;
            return 1'b1;
        end
        slot    = slot + 2'd1;
        pending = 1'b1;
        return 1'b0;
    endfunction

    always @(posedge aclk) begin : word_check
        odgp_pkg::word_t predicted;
        if (!aresetn) begin
            dither_low  = '0;
            dither_high = '0;
            fast_mode   = 1'b0;
            word_buf    = '0;
            slot        = '0;
            pending     = 1'b0;
            errors      = 0;
            expected_words.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    if (errors < REPORT_LIMIT) begin
                        $display("%0t: unexpected word %h last %0b", $time,
                                 m_data.packed_word, m_data.last_word);
                    end
                    errors++;
                end else begin
                    predicted = expected_words.pop_front();
                    if (m_data.packed_word !== predicted.packed_word ||
                        m_data.last_word !== predicted.last_word) begin
                        if (errors < REPORT_LIMIT) begin
                            $display("%0t: word exp %h last %0b, got %h last %0b", $time,
                                     predicted.packed_word, predicted.last_word,
                                     m_data.packed_word, m_data.last_word);
                        end
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (pack_pixel(s_data, predicted)) begin
                    expected_words.push_back(predicted);
                end
            end
            // register writes apply from the next pixel on
            if (psel && penable && pwrite && pready) begin
                case (paddr[odgp_pkg::APB_AW-1:3])
                    odgp_pkg::REG_DITHER_LOW:  dither_low  = pwdata;
                    odgp_pkg::REG_DITHER_HIGH: dither_high = pwdata;
                    odgp_pkg::REG_FAST_MODE:   fast_mode   = pwdata[0];
                    default: ;
                endcase
            end
        end
        mismatches <= errors;
        words_due  <= expected_words.size();
    end

endmodule

@@ tb/tb_ordered_dither_gray4_packer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ordered_dither_gray4_packer
// Drives pixels and APB writes into the packer under several dither tables,
// both output modes and varying back-pressure; a checker predicts the words.
// ----------------------------------------------------------------------------
module tb_ordered_dither_gray4_packer;

    localparam int         COORD_W         = odgp_pkg::COORD_BITS;
    localparam int         WATCHDOG_LIMIT  = 2000;
    localparam int         HOLD_OFF_CYCLES = 300;
    localparam int         SETTLE_CYCLES   = 6;
    localparam int         PHASE_PIXELS    = 226;
    localparam int         PHASE_COUNT     = 5;
    localparam logic [1:0] REG_UNUSED      = 2'd3;

    // 4x4 Bayer matrix as offsets (v - 8) * 4
    localparam logic [63:0] BAYER_LOW  = 64'hF818_F010_08E8_00E0;
    localparam logic [63:0] BAYER_HIGH = 64'hF414_FC1C_04E4_0CEC;

    logic                        aclk;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    odgp_pkg::pixel_t            s_data  = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    odgp_pkg::word_t             m_data;
    logic                        psel    = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite  = 1'b0;
    logic [odgp_pkg::APB_AW-1:0] paddr   = '0;
    logic [odgp_pkg::APB_DW-1:0] pwdata  = '0;
    logic [odgp_pkg::APB_DW-1:0] prdata;
    logic                        pready;

    int   mismatches;
    int   words_due;
    int   send_idle_pct = 0;
    int   rx_stall_pct  = 0;
    logic rx_hold       = 1'b0;
    event hold_off_start;

    ordered_dither_gray4_packer DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    odgp_word_checker word_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .mismatches (mismatches),
        .words_due  (words_due)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // long receiver hold-off so the packer backs up into its input
    initial forever begin
        @(hold_off_start);
        rx_hold <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

    function automatic odgp_pkg::pixel_t make_pixel(input int r, input int g, input int b,
                                                    input int col, input int row,
                                                    input bit seg);
        odgp_pkg::pixel_t px;
        px.red         = r[7:0];
        px.green       = g[7:0];
        px.blue        = b[7:0];
        px.column      = col[COORD_W-1:0];
        px.row         = row[COORD_W-1:0];
        px.segment_end = seg;
        return px;
    endfunction

    function automatic logic [7:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_pixel(input odgp_pkg::pixel_t px);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic cfg_write(input logic [1:0] reg_idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // drain all expected words, then let the pipeline empty
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (words_due != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly column runs closed by segment_end, mixed with stray pixels
    task automatic send_runs(input int count, input bit with_hold_off);
        odgp_pkg::pixel_t px;
        int               sent;
        int               run_len;
        sent = 0;
        while (sent < count) begin
            px.column = COORD_W'($urandom_range(0, 4095));
            px.row    = COORD_W'($urandom_range(0, 4095));
            run_len   = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 10);
            for (int i = 0; i < run_len && sent < count; i++) begin
                px.red   = pick_level();
                px.green = pick_level();
                px.blue  = pick_level();
                if (run_len == 1) begin
                    px.segment_end = ($urandom_range(0, 2) == 0);
                end else begin
                    px.segment_end = (i == run_len - 1) && ($urandom_range(0, 9) != 0);
                end
                if (with_hold_off && sent == 40) begin
                    -> hold_off_start;
                end
                send_pixel(px);
                sent++;
                px.column = ($urandom_range(0, 9) == 0) ?
                            COORD_W'($urandom_range(0, 4095)) : px.column + COORD_W'(1);
            end
        end
    endtask

    initial begin : stimulus
        logic [63:0] low;
        logic [63:0] high;
        logic [63:0] wide;
        bit          fast;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // reset table is all zero offsets, sixteen-level mode
        send_pixel(make_pixel(0, 0, 0, 0, 0, 1));
        send_pixel(make_pixel(255, 255, 255, 3, 3, 0));       // word closed by slot 3 alone
        send_pixel(make_pixel(255, 255, 255, 4095, 4095, 1)); // slot 3 with segment end
        send_pixel(make_pixel(255, 0, 0, 0, 1, 0));
        send_pixel(make_pixel(0, 255, 0, 1, 1, 0));
        send_pixel(make_pixel(0, 0, 255, 2, 1, 0));
        send_pixel(make_pixel(128, 128, 128, 3, 1, 0));
        send_pixel(make_pixel(64, 64, 64, 1, 2, 0));          // new word opens at slot 1
        send_pixel(make_pixel(255, 255, 0, 10, 2, 0));
        send_pixel(make_pixel(0, 255, 255, 7, 2, 0));
        send_pixel(make_pixel(1, 1, 1, 0, 3, 0));
        send_pixel(make_pixel(200, 100, 50, 1, 3, 1));        // flush, low nibbles zero
        send_pixel(make_pixel(255, 255, 255, 2, 2, 1));
        send_pixel(make_pixel(63, 0, 0, 4092, 4095, 0));
        send_pixel(make_pixel(0, 32, 0, 4093, 4095, 0));
        send_pixel(make_pixel(0, 0, 64, 4094, 4095, 1));
        send_pixel(make_pixel(17, 34, 51, 1, 0, 0));
        send_pixel(make_pixel(170, 85, 240, 0, 0, 1));

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            settle();
            case (ph)
                0: begin
                    low = BAYER_LOW;   high = BAYER_HIGH;  fast = 1'b0;
                    send_idle_pct = 0;  rx_stall_pct <= 0;
                end
                1: begin
                    low = {8{8'h80}};  high = {8{8'h7F}};  fast = 1'b1;
                    send_idle_pct = 64; rx_stall_pct <= 0;
                end
                2: begin
                    low = {8{8'h7F}};  high = {8{8'h80}};  fast = 1'b0;
                    send_idle_pct = 0;  rx_stall_pct <= 64;
                end
                3: begin
                    low = {$urandom, $urandom}; high = {$urandom, $urandom}; fast = 1'b1;
                    send_idle_pct = 20; rx_stall_pct <= 20;
                end
                default: begin
                    low = {$urandom, $urandom}; high = {$urandom, $urandom}; fast = 1'b0;
                    send_idle_pct = 20; rx_stall_pct <= 20;
                end
            endcase
            wide = {$urandom, $urandom};
            cfg_write(odgp_pkg::REG_DITHER_LOW, low);
            cfg_write(odgp_pkg::REG_DITHER_HIGH, high);
            cfg_write(odgp_pkg::REG_FAST_MODE, {wide[63:1], fast});
            if (ph == PHASE_COUNT - 1) begin
                // unmapped register slot must not disturb the table
                cfg_write(REG_UNUSED, {$urandom, $urandom});
            end
            send_runs(PHASE_PIXELS, ph == 3);
        end

        settle();
        if (mismatches == 0 && words_due == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
